[design/cpu_8bit_load_store_unit_assert.svh]
// Assertion macros for the 8-bit load/store unit.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef CPU_8BIT_LOAD_STORE_UNIT_ASSERT_SVH
`define CPU_8BIT_LOAD_STORE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define LSU8_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsu8 assertion failed");

// Next-cycle implication.
`define LSU8_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsu8 assertion failed");

`endif

[design/lsu8_pkg.sv]
// Types and constants for the 8-bit load/store unit.
// No dependencies.
`default_nettype none

package lsu8_pkg;

    typedef enum logic [3:0] {
        CMD_MOV      = 4'd0,
        CMD_LD_IMM   = 4'd1,
        CMD_LD_HL    = 4'd2,
        CMD_ST_HL    = 4'd3,
        CMD_ST_HL_I  = 4'd4,
        CMD_ST_HI_I  = 4'd5,
        CMD_ST_HI_C  = 4'd6,
        CMD_LD_HI_I  = 4'd7,
        CMD_LD_HI_C  = 4'd8,
        CMD_LD_PAIR  = 4'd9,
        CMD_ST_PAIR  = 4'd10,
        CMD_RET      = 4'd11
    } cmd_t;

    localparam logic [2:0] SEL_B    = 3'd0;
    localparam logic [2:0] SEL_C    = 3'd1;
    localparam logic [2:0] SEL_D    = 3'd2;
    localparam logic [2:0] SEL_E    = 3'd3;
    localparam logic [2:0] SEL_H    = 3'd4;
    localparam logic [2:0] SEL_L    = 3'd5;
    localparam logic [2:0] SEL_A    = 3'd6;
    localparam logic [2:0] SEL_NONE = 3'd7;

    localparam logic [1:0] PAIR_BC    = 2'd0;
    localparam logic [1:0] PAIR_DE    = 2'd1;
    localparam logic [1:0] PAIR_HL_INC = 2'd2;
    localparam logic [1:0] PAIR_HL_DEC = 2'd3;

    localparam logic [7:0] HIGH_PAGE = 8'hFF;
    localparam int         NUM_REGS  = 7;

    // Packed so that mem_valid lands in bit 0 of m_tdata.
    typedef struct packed {
        logic [5:0]  pad;
        logic [7:0]  reg_l;
        logic [7:0]  reg_h;
        logic [7:0]  reg_e;
        logic [7:0]  reg_d;
        logic [7:0]  reg_c;
        logic [7:0]  reg_b;
        logic [7:0]  reg_a;
        logic [7:0]  mem_wdata;
        logic [15:0] mem_addr;
        logic        mem_write;
        logic        mem_valid;
    } result_t;

endpackage

`default_nettype wire

[design/cpu_8bit_load_store_unit.sv]
// 8-bit load/store unit: register file, pending-read tracking and one result
// register. One transaction per cycle in each direction unless the output
// stalls; each result is registered. The register file and read tracking
// update at the accepting edge, so the next transaction sees them at once.
// Input is taken whenever the result register is empty or being drained.
// Depends on lsu8_pkg and cpu_8bit_load_store_unit_assert.svh.
`default_nettype none
`include "cpu_8bit_load_store_unit_assert.svh"

module cpu_8bit_load_store_unit
    import lsu8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,  // dst_sel, src_sel, pair_sel, imm_byte, mem_data
    input  wire logic [3:0]  s_tuser,  // cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [87:0]      m_tdata   // mem_valid, mem_write, mem_addr, mem_wdata,
                                       // reg_a, reg_b, reg_c, reg_d, reg_e, reg_h,
                                       // reg_l, zero pad
);

    logic [7:0] rf_reg  [NUM_REGS];
    logic [7:0] rf_next [NUM_REGS];
    logic       pend_reg;
    logic       pend_next;
    logic [2:0] tgt_reg;
    logic [2:0] tgt_next;
    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    result_t    res_reg;
    result_t    res_next;

    cmd_t       cmd;
    logic [2:0] dst_sel;
    logic [2:0] src_sel;
    logic [1:0] pair_sel;
    logic [7:0] imm_byte;
    logic [7:0] mem_data;
    logic       accept;

    logic [7:0]  src_val;
    logic [15:0] hl;
    logic [15:0] pair_addr;
    logic        acc_valid;
    logic        acc_write;
    logic [15:0] acc_addr;
    logic [7:0]  acc_wdata;
    logic        rd_req;
    logic [2:0]  rd_tgt;
    logic        wr_en;
    logic [2:0]  wr_sel;
    logic [7:0]  wr_val;
    logic        hl_en;
    logic [15:0] hl_val;

    assign cmd      = cmd_t'(s_tuser);
    assign dst_sel  = s_tdata[2:0];
    assign src_sel  = s_tdata[5:3];
    assign pair_sel = s_tdata[7:6];
    assign imm_byte = s_tdata[15:8];
    assign mem_data = s_tdata[23:16];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign src_val = (src_sel != SEL_NONE) ? rf_reg[src_sel] : 8'd0;
    assign hl      = {rf_reg[SEL_H], rf_reg[SEL_L]};

    always_comb
    begin
        case (pair_sel)
            PAIR_BC: pair_addr = {rf_reg[SEL_B], rf_reg[SEL_C]};
            PAIR_DE: pair_addr = {rf_reg[SEL_D], rf_reg[SEL_E]};
            default: pair_addr = hl;
        endcase
    end

    always_comb
    begin
        acc_valid = 1'b0;
        acc_write = 1'b0;
        acc_addr  = 16'd0;
        acc_wdata = 8'd0;
        rd_req    = 1'b0;
        rd_tgt    = SEL_A;
        wr_en     = 1'b0;
        wr_sel    = dst_sel;
        wr_val    = src_val;
        hl_en     = 1'b0;
        hl_val    = hl;
        case (cmd)
            CMD_MOV:
            begin
                wr_en = 1'b1;
            end
            CMD_LD_IMM:
            begin
                wr_en  = 1'b1;
                wr_val = imm_byte;
            end
            CMD_LD_HL:
            begin
                rd_req   = 1'b1;
                rd_tgt   = dst_sel;
                acc_addr = hl;
            end
            CMD_ST_HL:
            begin
                acc_write = 1'b1;
                acc_addr  = hl;
                acc_wdata = src_val;
            end
            CMD_ST_HL_I:
            begin
                acc_write = 1'b1;
                acc_addr  = hl;
                acc_wdata = imm_byte;
            end
            CMD_ST_HI_I:
            begin
                acc_write = 1'b1;
                acc_addr  = {HIGH_PAGE, imm_byte};
                acc_wdata = rf_reg[SEL_A];
            end
            CMD_ST_HI_C:
            begin
                acc_write = 1'b1;
                acc_addr  = {HIGH_PAGE, rf_reg[SEL_C]};
                acc_wdata = rf_reg[SEL_A];
            end
            CMD_LD_HI_I:
            begin
                rd_req   = 1'b1;
                acc_addr = {HIGH_PAGE, imm_byte};
            end
            CMD_LD_HI_C:
            begin
                rd_req   = 1'b1;
                acc_addr = {HIGH_PAGE, rf_reg[SEL_C]};
            end
            CMD_LD_PAIR, CMD_ST_PAIR:
            begin
                acc_addr = pair_addr;
                if (cmd == CMD_LD_PAIR)
                begin
                    rd_req = 1'b1;
                end
                else
                begin
                    acc_write = 1'b1;
                    acc_wdata = rf_reg[SEL_A];
                end
                hl_en  = pair_sel[1];
                hl_val = (pair_sel == PAIR_HL_INC) ? hl + 16'd1 : hl - 16'd1;
            end
            CMD_RET:
            begin
                wr_en  = pend_reg;
                wr_sel = tgt_reg;
                wr_val = mem_data;
            end
            default:
            begin
            end
        endcase
        acc_valid = acc_write || rd_req;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            rf_next[i] = rf_reg[i];
            if (accept && wr_en && wr_sel == 3'(i))
                rf_next[i] = wr_val;
        end
        if (accept && hl_en)
        begin
            rf_next[SEL_H] = hl_val[15:8];
            rf_next[SEL_L] = hl_val[7:0];
        end

        pend_next = pend_reg;
        tgt_next  = tgt_reg;
        if (accept)
        begin
            if (rd_req)
            begin
                pend_next = 1'b1;
                tgt_next  = rd_tgt;
            end
            else if (cmd == CMD_RET)
            begin
                pend_next = 1'b0;
            end
        end

        m_tvalid_next = accept || (m_tvalid_reg && !m_tready);

        res_next           = res_reg;
        if (accept)
        begin
            res_next.pad       = '0;
            res_next.mem_valid = acc_valid;
            res_next.mem_write = acc_write;
            res_next.mem_addr  = acc_valid ? acc_addr : 16'd0;
            res_next.mem_wdata = acc_wdata;
            res_next.reg_a     = rf_next[SEL_A];
            res_next.reg_b     = rf_next[SEL_B];
            res_next.reg_c     = rf_next[SEL_C];
            res_next.reg_d     = rf_next[SEL_D];
            res_next.reg_e     = rf_next[SEL_E];
            res_next.reg_h     = rf_next[SEL_H];
            res_next.reg_l     = rf_next[SEL_L];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                rf_reg[i] <= 8'd0;
            pend_reg     <= 1'b0;
            tgt_reg      <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rf_reg       <= rf_next;
            pend_reg     <= pend_next;
            tgt_reg      <= tgt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = res_reg;

    `LSU8_ASSERT_NOW(a_regs_match, m_tvalid_reg,
        res_reg.reg_a == rf_reg[SEL_A] && res_reg.reg_h == rf_reg[SEL_H] &&
        res_reg.reg_l == rf_reg[SEL_L] && res_reg.reg_c == rf_reg[SEL_C])
    `LSU8_ASSERT_NOW(a_write_is_access, m_tvalid_reg && res_reg.mem_write,
        res_reg.mem_valid)
    `LSU8_ASSERT_NEXT(a_read_sets_pending, accept && rd_req, pend_reg)
    `LSU8_ASSERT_NEXT(a_return_clears, accept && cmd == CMD_RET && pend_reg,
        !pend_reg && m_tvalid_reg && !res_reg.mem_valid)
    `LSU8_ASSERT_NOW(a_idle_no_change, !accept,
        pend_next == pend_reg && tgt_next == tgt_reg)

endmodule

`default_nettype wire
